// File: rtl/iib_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the integral image box filter
// no dependencies
package iib_pkg;

  // default table size limits
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int MAX_WIDTH_DEF  = 64;

  // field widths
  localparam int COORD_W = 7;
  localparam int DATA_W  = 32;
  localparam int SCALE_W = 17;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // signed work width for corner arithmetic, covers every table limit
  localparam int CORNER_W = 12;

  // four-corner sum, product and scaled value widths
  localparam int ACC_W      = DATA_W + 2;
  localparam int PROD_W     = ACC_W + SCALE_W + 1;
  localparam int FRAC_SHIFT = 16;
  localparam int SCALED_W   = PROD_W - FRAC_SHIFT;

  // commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // clamp modes
  localparam logic MODE_NORM = 1'b0;
  localparam logic MODE_REPL = 1'b1;

  // register indexes
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [2:0] REG_TOP_OFFSET    = 3'd2;
  localparam logic [2:0] REG_BOTTOM_OFFSET = 3'd3;
  localparam logic [2:0] REG_LEFT_OFFSET   = 3'd4;
  localparam logic [2:0] REG_RIGHT_OFFSET  = 3'd5;
  localparam logic [2:0] REG_AREA_SCALE    = 3'd6;
  localparam logic [2:0] REG_CLAMP_MODE    = 3'd7;

  typedef struct packed {
    logic        [COORD_W-1:0] image_height;
    logic        [COORD_W-1:0] image_width;
    logic signed [7:0]         top_offset;
    logic signed [7:0]         bottom_offset;
    logic signed [7:0]         left_offset;
    logic signed [7:0]         right_offset;
    logic        [SCALE_W-1:0] area_scale;
    logic                      clamp_mode;
  } cfg_t;

  // sequencer controls for the accumulate and scale unit
  typedef struct packed {
    logic acc_en;
    logic acc_first;
    logic acc_neg;
    logic mul_en;
  } acc_ctl_t;

endpackage

// File: rtl/iib_table.sv
`timescale 1ns / 1ps
// summed-area table storage, single port, registered read
// no dependencies
module iib_table #(
  parameter int DEPTH = 4225,
  parameter int AW    = 13,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/iib_clamp.sv
`timescale 1ns / 1ps
// box corner computation and clamping for one query
// depends on iib_pkg
module iib_clamp #(
  parameter int MAX_HEIGHT = iib_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = iib_pkg::MAX_WIDTH_DEF,
  parameter int RW         = $clog2(MAX_HEIGHT + 1),
  parameter int CWD        = $clog2(MAX_WIDTH + 1)
) (
  input  iib_pkg::cfg_t                     cfg,
  input  logic [iib_pkg::COORD_W-1:0]       row,
  input  logic [iib_pkg::COORD_W-1:0]       col,
  output logic [RW-1:0]                     top_row,
  output logic [RW-1:0]                     bottom_row,
  output logic [CWD-1:0]                    left_col,
  output logic [CWD-1:0]                    right_col
);

  localparam int CW = iib_pkg::CORNER_W;
  localparam int PAD = CW - iib_pkg::COORD_W;
  localparam logic signed [CW-1:0] H_MAX = CW'(MAX_HEIGHT);
  localparam logic signed [CW-1:0] W_MAX = CW'(MAX_WIDTH);
  localparam logic signed [CW-1:0] ONE   = CW'(1);
  localparam logic signed [CW-1:0] ZERO  = CW'(0);

  function automatic logic signed [CW-1:0] clip(input logic signed [CW-1:0] v,
                                                input logic signed [CW-1:0] lo,
                                                input logic signed [CW-1:0] hi);
    if (v < lo) begin
      clip = lo;
    end else if (v > hi) begin
      clip = hi;
    end else begin
      clip = v;
    end
  endfunction

  logic signed [CW-1:0] h_raw, w_raw, h_lim, w_lim;
  logic signed [CW-1:0] row_s, col_s;
  logic signed [CW-1:0] t_sum, b_sum, l_sum, r_sum;
  logic signed [CW-1:0] lo_far, h_near, w_near;

  assign h_raw = $signed({{PAD{1'b0}}, cfg.image_height});
  assign w_raw = $signed({{PAD{1'b0}}, cfg.image_width});
  assign row_s = $signed({{PAD{1'b0}}, row});
  assign col_s = $signed({{PAD{1'b0}}, col});

  // size registers saturated to the table limits
  assign h_lim = clip(h_raw, ONE, H_MAX);
  assign w_lim = clip(w_raw, ONE, W_MAX);

  assign t_sum = row_s + CW'(cfg.top_offset);
  assign b_sum = row_s + CW'(cfg.bottom_offset);
  assign l_sum = col_s + CW'(cfg.left_offset);
  assign r_sum = col_s + CW'(cfg.right_offset);

  // replicate mode keeps the box at least one pixel inside the image
  always_comb begin
    if (cfg.clamp_mode == iib_pkg::MODE_REPL) begin
      lo_far = ONE;
      h_near = h_lim - ONE;
      w_near = w_lim - ONE;
    end else begin
      lo_far = ZERO;
      h_near = h_lim;
      w_near = w_lim;
    end
  end

  assign top_row    = RW'(clip(t_sum, ZERO, h_near));
  assign bottom_row = RW'(clip(b_sum, lo_far, h_lim));
  assign left_col   = CWD'(clip(l_sum, ZERO, w_near));
  assign right_col  = CWD'(clip(r_sum, lo_far, w_lim));

endmodule

// File: rtl/iib_accum.sv
`timescale 1ns / 1ps
// four-corner accumulate, area scaling and saturation; replicate mode saturates the unscaled sum
// depends on iib_pkg
module iib_accum (
  input  logic                            clk,
  input  iib_pkg::acc_ctl_t               ctl,
  input  logic                            clamp_mode,
  input  logic [iib_pkg::SCALE_W-1:0]     area_scale,
  input  logic [iib_pkg::DATA_W-1:0]      rd_data,
  output logic [iib_pkg::DATA_W-1:0]      result
);

  localparam int AW_ = iib_pkg::ACC_W;
  localparam int PW  = iib_pkg::PROD_W;
  localparam int SW  = iib_pkg::SCALED_W;
  localparam int DW  = iib_pkg::DATA_W;

  logic signed [AW_-1:0] acc;
  logic signed [AW_-1:0] term;
  logic signed [PW-1:0]  prod;
  logic signed [SW-1:0]  scaled;

  assign term = ctl.acc_neg ? -AW_'($signed(rd_data)) : AW_'($signed(rd_data));

  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      acc <= ctl.acc_first ? term : acc + term;
    end
    if (ctl.mul_en) begin
      prod <= acc * $signed({1'b0, area_scale});
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign scaled = prod[PW-1:iib_pkg::FRAC_SHIFT];

  always_comb begin
    if (clamp_mode == iib_pkg::MODE_NORM) begin
      if (scaled[SW-1:DW-1] == '0 || scaled[SW-1:DW-1] == '1) begin
        result = scaled[DW-1:0];
      end else begin
        result = scaled[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end
    end else begin
      if (acc[AW_-1:DW-1] == '0 || acc[AW_-1:DW-1] == '1) begin
        result = acc[DW-1:0];
      end else begin
        result = acc[AW_-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end
    end
  end

endmodule

// File: rtl/integral_image_box_filter.sv
`timescale 1ns / 1ps
// top level of the box filter over a summed-area table
// depends on iib_pkg, iib_table, iib_clamp, iib_accum
//
// the block keeps a (MAX_HEIGHT+1) x (MAX_WIDTH+1) summed-area table in one
// single-port memory with a registered read. a load transfer (cmd = load)
// writes one entry in the cycle it is taken; loads outside the table are
// dropped. a query transfer (cmd = query) puts its box_sum into the output
// register through the sequencer states: read issues the four corner reads
// through the single memory port, last collects the last read, mul forms the
// area-scaling product and done saturates into the output register. the
// sequencer then returns to idle, where the next item is taken. most of a
// query's time goes to the four reads through the one memory port. the
// output register lets the next item be taken while a result still waits; a
// query only stalls at its last step, for as long as the previous result is
// still held. the table has no reset: every entry must be loaded before a
// query reads it. configuration goes through the apb port and should only be
// written while no query is in flight.
module integral_image_box_filter #(
  parameter int MAX_HEIGHT = iib_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = iib_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // item channel
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic                                cmd,
  input  logic [iib_pkg::COORD_W-1:0]         row,
  input  logic [iib_pkg::COORD_W-1:0]         col,
  input  logic signed [iib_pkg::DATA_W-1:0]   entry_value,
  // result channel
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic signed [iib_pkg::DATA_W-1:0]   box_sum,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [iib_pkg::PADDR_W-1:0]         paddr,
  input  logic [iib_pkg::PDATA_W-1:0]         pwdata,
  output logic [iib_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int STRIDE = MAX_WIDTH + 1;
  localparam int DEPTH  = (MAX_HEIGHT + 1) * STRIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int RW     = $clog2(MAX_HEIGHT + 1);
  localparam int CWD    = $clog2(MAX_WIDTH + 1);
  localparam int CW     = iib_pkg::CORNER_W;

  // corner read order, signs are + - - +
  localparam logic [1:0] CORNER_BR = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BL = 2'd2;
  localparam logic [1:0] CORNER_TL = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_LAST = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  iib_pkg::cfg_t     cfg;
  iib_pkg::acc_ctl_t acc_ctl;

  logic [1:0]     corner;
  logic           rd_valid;
  logic [1:0]     rd_corner;

  logic [RW-1:0]  top_row, bottom_row, top_q, bottom_q;
  logic [CWD-1:0] left_col, right_col, left_q, right_q;
  logic [RW-1:0]  sel_row;
  logic [CWD-1:0] sel_col;

  logic                        req_xfer, rsp_xfer, cfg_wr;
  logic                        load_ok;
  logic                        mem_we;
  logic [AW-1:0]               mem_addr, load_addr, read_addr;
  logic [iib_pkg::DATA_W-1:0]  mem_rdata;
  logic [iib_pkg::DATA_W-1:0]  result;
  logic [2:0]                  reg_index;

  assign req_xfer  = req_valid && req_ready;
  assign rsp_xfer  = rsp_valid && rsp_ready;
  assign req_ready = (state == ST_IDLE);
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign reg_index = paddr[4:2];

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_height  <= iib_pkg::COORD_W'(64);
      cfg.image_width   <= iib_pkg::COORD_W'(64);
      cfg.top_offset    <= 8'sd0;
      cfg.bottom_offset <= 8'sd1;
      cfg.left_offset   <= 8'sd0;
      cfg.right_offset  <= 8'sd1;
      cfg.area_scale    <= iib_pkg::SCALE_W'(65536);
      cfg.clamp_mode    <= iib_pkg::MODE_NORM;
    end else if (cfg_wr) begin
      case (reg_index)
        iib_pkg::REG_IMAGE_HEIGHT:  cfg.image_height  <= pwdata[iib_pkg::COORD_W-1:0];
        iib_pkg::REG_IMAGE_WIDTH:   cfg.image_width   <= pwdata[iib_pkg::COORD_W-1:0];
        iib_pkg::REG_TOP_OFFSET:    cfg.top_offset    <= $signed(pwdata[7:0]);
        iib_pkg::REG_BOTTOM_OFFSET: cfg.bottom_offset <= $signed(pwdata[7:0]);
        iib_pkg::REG_LEFT_OFFSET:   cfg.left_offset   <= $signed(pwdata[7:0]);
        iib_pkg::REG_RIGHT_OFFSET:  cfg.right_offset  <= $signed(pwdata[7:0]);
        iib_pkg::REG_AREA_SCALE:    cfg.area_scale    <= pwdata[iib_pkg::SCALE_W-1:0];
        iib_pkg::REG_CLAMP_MODE:    cfg.clamp_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back, zero-extended
  always_comb begin
    case (reg_index)
      iib_pkg::REG_IMAGE_HEIGHT:  prdata = iib_pkg::PDATA_W'(cfg.image_height);
      iib_pkg::REG_IMAGE_WIDTH:   prdata = iib_pkg::PDATA_W'(cfg.image_width);
      iib_pkg::REG_TOP_OFFSET:    prdata = {24'b0, cfg.top_offset};
      iib_pkg::REG_BOTTOM_OFFSET: prdata = {24'b0, cfg.bottom_offset};
      iib_pkg::REG_LEFT_OFFSET:   prdata = {24'b0, cfg.left_offset};
      iib_pkg::REG_RIGHT_OFFSET:  prdata = {24'b0, cfg.right_offset};
      iib_pkg::REG_AREA_SCALE:    prdata = iib_pkg::PDATA_W'(cfg.area_scale);
      iib_pkg::REG_CLAMP_MODE:    prdata = iib_pkg::PDATA_W'(cfg.clamp_mode);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // corner clamping, captured at the query transfer
  // ---------------------------------------------------------------------
  iib_clamp #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .RW         (RW),
    .CWD        (CWD)
  ) u_clamp (
    .cfg        (cfg),
    .row        (row),
    .col        (col),
    .top_row    (top_row),
    .bottom_row (bottom_row),
    .left_col   (left_col),
    .right_col  (right_col)
  );

  always_ff @(posedge clk) begin
    if (req_xfer && cmd == iib_pkg::CMD_QUERY) begin
      top_q    <= top_row;
      bottom_q <= bottom_row;
      left_q   <= left_col;
      right_q  <= right_col;
    end
  end

  // ---------------------------------------------------------------------
  // memory port: loads write in idle, queries read one corner a cycle
  // ---------------------------------------------------------------------
  assign load_ok = ({{(CW-iib_pkg::COORD_W){1'b0}}, row} <= CW'(MAX_HEIGHT)) &&
                   ({{(CW-iib_pkg::COORD_W){1'b0}}, col} <= CW'(MAX_WIDTH));

  assign load_addr = AW'(row) * AW'(STRIDE) + AW'(col);

  assign sel_row = (corner == CORNER_BR || corner == CORNER_BL) ? bottom_q : top_q;
  assign sel_col = (corner == CORNER_BR || corner == CORNER_TR) ? right_q : left_q;
  assign read_addr = AW'(sel_row) * AW'(STRIDE) + AW'(sel_col);

  assign mem_we   = req_xfer && cmd == iib_pkg::CMD_LOAD && load_ok;
  assign mem_addr = (state == ST_READ) ? read_addr : load_addr;

  iib_table #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (iib_pkg::DATA_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (entry_value),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_xfer && cmd == iib_pkg::CMD_QUERY) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (corner == CORNER_TL) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: state_next = ST_MUL;
      ST_MUL:  state_next = ST_DONE;
      ST_DONE: begin
        // wait while the previous result still sits in the output register
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      corner    <= CORNER_BR;
      rd_valid  <= 1'b0;
      rd_corner <= CORNER_BR;
    end else begin
      state     <= state_next;
      rd_valid  <= (state == ST_READ);
      rd_corner <= corner;
      if (state == ST_READ) begin
        corner <= corner + 2'd1;
      end else begin
        corner <= CORNER_BR;
      end
    end
  end

  // read data lands in the cycle after its address
  assign acc_ctl.acc_en    = rd_valid;
  assign acc_ctl.acc_first = (rd_corner == CORNER_BR);
  assign acc_ctl.acc_neg   = (rd_corner == CORNER_TR) || (rd_corner == CORNER_BL);
  assign acc_ctl.mul_en    = (state == ST_MUL);

  iib_accum u_accum (
    .clk        (clk),
    .ctl        (acc_ctl),
    .clamp_mode (cfg.clamp_mode),
    .area_scale (cfg.area_scale),
    .rd_data    (mem_rdata),
    .result     (result)
  );

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_xfer) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!rsp_valid || rsp_ready)) begin
      box_sum <= $signed(result);
    end
  end

endmodule

// File: rtl/iib_checker.sv
`timescale 1ns / 1ps
// port-level checks for the box filter top level, with its bind
// depends on iib_pkg and integral_image_box_filter
module iib_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       cmd,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [iib_pkg::DATA_W-1:0] box_sum
);

  logic load_xfer, query_xfer;

  assign load_xfer  = req_valid && req_ready && cmd == iib_pkg::CMD_LOAD;
  assign query_xfer = req_valid && req_ready && cmd == iib_pkg::CMD_QUERY;

  // a held result does not change
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(box_sum))
    else $error("result changed or dropped while stalled");

  // after a load the next item may follow at once
  a_load_single: assert property (@(posedge clk) disable iff (rst)
    load_xfer |=> req_ready)
    else $error("not ready after a load");

  // a query occupies the sequencer
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    query_xfer |=> !req_ready)
    else $error("ready right after a query");

  // a rising rsp_valid must match an earlier query transfer
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(query_xfer, 8))
    else $error("result without a matching query");

endmodule

bind integral_image_box_filter iib_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .box_sum   (box_sum)
);
